[rtl/tdb_pkg.sv]
// Shared constants for the touch detector with baseline tracking.
// No dependencies; imported by tdb_lane and touch_detect_baseline_ema.
package tdb_pkg;

    localparam int CHANNELS        = 7;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int THRESH_BITS     = 10;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(3);

endpackage

[rtl/tdb_lane.sv]
// One electrode lane: optional baseline load, touch compare, 4:1 baseline blend.
// Depends on tdb_pkg for the threshold width.
module tdb_lane #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]           baseline,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic [tdb_pkg::THRESH_BITS-1:0]  threshold,
    input  logic                             load,
    output logic                             touched,
    output logic [SAMPLE_BITS-1:0]           baseline_upd
);
    import tdb_pkg::*;

    localparam int CW = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 1;
    localparam int XW = SAMPLE_BITS + 3;
    localparam int K  = XW + 3;
    localparam int PW = XW + K;
    localparam int unsigned RECIP5 = ((2 ** K) + 4) / 5;

    logic [SAMPLE_BITS-1:0] base_eff;
    logic [CW-1:0]          lhs;
    logic [CW-1:0]          rhs;
    logic [XW-1:0]          blend_sum;
    logic [PW-1:0]          prod;

    assign base_eff  = load ? sample : baseline;
    assign lhs       = CW'(base_eff);
    assign rhs       = CW'(sample) + CW'(threshold);
    assign touched   = (lhs >= rhs);

    // floor(x/5) as x * ceil(2^K/5) >> K, exact over the XW-bit range
    assign blend_sum    = XW'({base_eff, 2'b00}) + XW'(sample);
    assign prod         = PW'(blend_sum) * PW'(RECIP5);
    assign baseline_upd = prod[K +: SAMPLE_BITS];

endmodule

[rtl/touch_detect_baseline_ema.sv]
// Top level of the touch detector: baseline store, lanes, mask merge, output skid.
// Depends on tdb_pkg and tdb_lane.
//
// Accepts one frame of seven electrode readings per cycle while the skid stage is empty
// and returns one touch mask per frame from the output register. All seven lanes work in
// parallel and combinationally; the per-channel baselines are updated at the edge
// that accepts the word, so consecutive words see each other's updates. A two-entry
// output register and skid stage keep input acceptance going while one mask waits.
// While channel 0's baseline is zero, all baselines load from the incoming frame.
module touch_detect_baseline_ema #(
    parameter int SAMPLE_BITS = tdb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tdb_pkg::THRESH_BITS-1:0] cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SAMPLE_BITS-1:0]          sample_0,
    input  logic [SAMPLE_BITS-1:0]          sample_1,
    input  logic [SAMPLE_BITS-1:0]          sample_2,
    input  logic [SAMPLE_BITS-1:0]          sample_3,
    input  logic [SAMPLE_BITS-1:0]          sample_4,
    input  logic [SAMPLE_BITS-1:0]          sample_5,
    input  logic [SAMPLE_BITS-1:0]          sample_6,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tdb_pkg::CHANNELS-1:0]    touch_mask
);
    import tdb_pkg::*;

    logic [SAMPLE_BITS-1:0] samples [CHANNELS];
    logic [SAMPLE_BITS-1:0] baseline_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0] baseline_next [CHANNELS];
    logic [THRESH_BITS-1:0] thresh_reg;
    logic [CHANNELS-1:0]    mask_next;
    logic                   load;
    logic                   in_fire;
    logic                   out_fire;

    logic                   out_vld_reg;
    logic [CHANNELS-1:0]    out_mask_reg;
    logic                   skid_vld_reg;
    logic [CHANNELS-1:0]    skid_mask_reg;

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;
    assign samples[4] = sample_4;
    assign samples[5] = sample_5;
    assign samples[6] = sample_6;

    assign load = (baseline_reg[0] == '0);

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        tdb_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .baseline     (baseline_reg[i]),
            .sample       (samples[i]),
            .threshold    (thresh_reg),
            .load         (load),
            .touched      (mask_next[i]),
            .baseline_upd (baseline_next[i])
        );
    end

    assign in_ready   = !skid_vld_reg;
    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_vld_reg && out_ready;
    assign out_valid  = out_vld_reg;
    assign touch_mask = out_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thresh_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                baseline_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                baseline_reg[i] <= baseline_next[i];
            end
        end
    end

    // output register plus skid; skid only fills when the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_reg <= 1'b1;
                end
                else
                begin
                    skid_vld_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_vld_reg  <= skid_vld_reg;
                skid_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_vld_reg || out_ready)
            begin
                out_mask_reg <= mask_next;
            end
            else
            begin
                skid_mask_reg <= mask_next;
            end
        end
        else if (out_fire && skid_vld_reg)
        begin
            out_mask_reg <= skid_mask_reg;
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a word while output register is empty");

    a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_vld_reg)
        else $error("accepted word produced no output");

    a_load_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && load && (sample_0 != '0)) |=> (baseline_reg[0] != '0))
        else $error("baseline load from nonzero sample left channel 0 at zero");

endmodule

[sim/touch_detect_baseline_ema_test.sv]
// Self-checking testbench for touch_detect_baseline_ema: a queue-fed driver, an output monitor
// and a built-in baseline tracker that predicts each touch mask. Depends on tdb_pkg and the RTL.
`timescale 1ns / 1ps

module touch_detect_baseline_ema_test;

    import tdb_pkg::*;

    localparam int SB       = SAMPLE_BITS_DEF;
    localparam int SMAX     = (1 << SB) - 1;
    localparam int TMAX     = (1 << THRESH_BITS) - 1;
    localparam int SETTLE   = 8;
    localparam int PHASE_SZ = 230;

    typedef logic [CHANNELS-1:0][SB-1:0] frame_t;
    typedef logic [CHANNELS-1:0]         mask_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [THRESH_BITS-1:0] cfg_wr_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SB-1:0]          sample_0 = '0;
    logic [SB-1:0]          sample_1 = '0;
    logic [SB-1:0]          sample_2 = '0;
    logic [SB-1:0]          sample_3 = '0;
    logic [SB-1:0]          sample_4 = '0;
    logic [SB-1:0]          sample_5 = '0;
    logic [SB-1:0]          sample_6 = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    mask_t                  touch_mask;

    frame_t                 frame_backlog[$];
    mask_t                  mask_due[$];
    frame_t                 on_wire = '0;
    logic [SB-1:0]          base_level [CHANNELS];
    logic [THRESH_BITS-1:0] thr_now = THRESH_RESET;
    bit                     no_idle = 1'b0;
    int                     frames_queued = 0;
    int                     frames_taken = 0;
    int                     masks_checked = 0;
    int                     masks_touched = 0;
    int                     thr_writes = 0;
    int                     fail_count = 0;

    touch_detect_baseline_ema i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_0    (sample_0),
        .sample_1    (sample_1),
        .sample_2    (sample_2),
        .sample_3    (sample_3),
        .sample_4    (sample_4),
        .sample_5    (sample_5),
        .sample_6    (sample_6),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .touch_mask  (touch_mask)
    );

    always #5 clk = ~clk;

    // baseline tracker: returns the mask for one frame and moves the baselines
    function automatic mask_t track_frame(frame_t f);
        mask_t       m;
        int unsigned b;
        int unsigned r;
        m = '0;
        if (base_level[0] == '0)
        begin
            for (int i = 0; i < CHANNELS; i++)
                base_level[i] = f[i];
        end
        for (int i = 0; i < CHANNELS; i++)
        begin
            b = base_level[i];
            r = f[i];
            if (b >= r + thr_now)
                m[i] = 1'b1;
            base_level[i] = SB'((4 * b + r) / 5);
        end
        return m;
    endfunction

    function automatic logic [SB-1:0] clip(int v);
        if (v < 0)
            return '0;
        if (v > SMAX)
            return SB'(SMAX);
        return SB'(v);
    endfunction

    function automatic frame_t flat_frame(int v);
        frame_t f;
        for (int i = 0; i < CHANNELS; i++)
            f[i] = clip(v);
        return f;
    endfunction

    task automatic queue_frame(frame_t f);
        frame_backlog.push_back(f);
        frames_queued++;
    endtask

    task automatic wait_idle();
        while (frame_backlog.size() != 0 || in_valid || mask_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THRESH_BITS-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        thr_now = v;
        thr_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // even channels sit exactly at the threshold, odd ones one count short of it
    task automatic queue_edge_frame();
        frame_t f;
        wait_idle();
        for (int i = 0; i < CHANNELS; i++)
            f[i] = clip(int'(base_level[i]) - int'(thr_now) + (i % 2));
        queue_frame(f);
    endtask

    // settled electrodes with small jitter and a press on some of them
    task automatic queue_steady();
        int    lvl [CHANNELS];
        int    len;
        int    dip_start;
        int    dip_len;
        int    depth;
        mask_t dip_mask;
        frame_t f;
        len       = $urandom_range(8, 40);
        dip_start = $urandom_range(0, len - 1);
        dip_len   = $urandom_range(1, 12);
        depth     = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 1023)
                                                : $urandom_range(1, 150);
        dip_mask  = mask_t'($urandom);
        for (int i = 0; i < CHANNELS; i++)
            lvl[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SMAX)
                                                 : $urandom_range(150, 900);
        for (int k = 0; k < len; k++)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                f[i] = clip(lvl[i] + $urandom_range(0, 8) - 4
                            - ((dip_mask[i] && k >= dip_start && k < dip_start + dip_len)
                               ? depth : 0));
            end
            queue_frame(f);
        end
    endtask

    // channel 0 held at zero until its baseline decays to zero and the frame reloads
    task automatic queue_decay();
        frame_t f;
        for (int k = 0; k < 32; k++)
        begin
            for (int i = 0; i < CHANNELS; i++)
                f[i] = SB'($urandom_range(0, SMAX));
            f[0] = '0;
            queue_frame(f);
        end
        f[0] = SB'($urandom_range(0, 3));
        queue_frame(f);
    endtask

    task automatic queue_noise();
        frame_t f;
        int     n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < CHANNELS; i++)
                f[i] = SB'($urandom);
            queue_frame(f);
        end
    endtask

    task automatic queue_random_phase();
        int goal;
        int pick;
        goal = frames_queued + PHASE_SZ;
        while (frames_queued < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                queue_steady();
            else if (pick < 80)
                queue_decay();
            else
                queue_noise();
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                mask_due.push_back(track_frame(on_wire));
                frames_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (frame_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 26))
                begin
                    on_wire  <= frame_backlog[0];
                    sample_0 <= frame_backlog[0][0];
                    sample_1 <= frame_backlog[0][1];
                    sample_2 <= frame_backlog[0][2];
                    sample_3 <= frame_backlog[0][3];
                    sample_4 <= frame_backlog[0][4];
                    sample_5 <= frame_backlog[0][5];
                    sample_6 <= frame_backlog[0][6];
                    in_valid <= 1'b1;
                    void'(frame_backlog.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        mask_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (mask_due.size() == 0)
                begin
                    $error("touch_mask: no word expected, got %b", touch_mask);
                    fail_count++;
                end
                else
                begin
                    want = mask_due.pop_front();
                    masks_checked++;
                    if (want != '0)
                        masks_touched++;
                    if (touch_mask !== want)
                    begin
                        $error("touch_mask: expected %b, actual %b", want, touch_mask);
                        fail_count++;
                    end
                end
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= 26);
        end
    end

    initial
    begin
        #2_000_000;
        $display("** touch_detect_baseline_ema: FAILED **");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
            base_level[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold, zero frames keep reloading
        queue_frame(flat_frame(0));
        queue_frame(flat_frame(0));

        // largest threshold: only a full-scale drop counts
        write_threshold(THRESH_BITS'(TMAX));
        queue_frame(flat_frame(SMAX));
        queue_frame(flat_frame(0));
        queue_frame(flat_frame(1));

        write_threshold(THRESH_RESET);
        queue_frame(flat_frame(SMAX));
        queue_frame(flat_frame(0));
        queue_frame(flat_frame('h2AA));
        queue_frame(flat_frame('h155));
        queue_edge_frame();

        write_threshold('0);
        queue_edge_frame();
        queue_frame(flat_frame(SMAX));

        write_threshold(THRESH_BITS'($urandom_range(1, 40)));
        queue_edge_frame();
        queue_random_phase();

        write_threshold('0);
        queue_random_phase();

        write_threshold(THRESH_RESET);
        no_idle = 1'b1;
        queue_random_phase();
        wait_idle();
        no_idle = 1'b0;

        write_threshold(THRESH_BITS'($urandom_range(0, TMAX)));
        queue_random_phase();

        write_threshold(THRESH_BITS'(TMAX));
        queue_random_phase();

        write_threshold(THRESH_BITS'($urandom_range(5, 120)));
        queue_random_phase();

        wait_idle();
        $display("%0d frames sent over %0d threshold settings, %0d masks checked (%0d with touches)",
                 frames_taken, thr_writes, masks_checked, masks_touched);
        if (fail_count == 0)
            $display("** touch_detect_baseline_ema: PASSED **");
        else
            $display("** touch_detect_baseline_ema: FAILED **");
        $finish;
    end

endmodule
